### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ovle_pkg.sv
// Package: types, codes and defaults of the ordered value list engine.
`default_nettype none
package ovle_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;

    localparam logic [2:0] FN_APPEND = 3'd0;
    localparam logic [2:0] FN_SEARCH = 3'd1;
    localparam logic [2:0] FN_EDIT   = 3'd2;
    localparam logic [2:0] FN_DELETE = 3'd3;
    localparam logic [2:0] FN_DUMP   = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [2:0]               func;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] new_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_SHRD,
        S_SHWR,
        S_DRD,
        S_DOUT,
        S_EMIT
    } t_state;

endpackage
`default_nettype wire

### rtl/ovle_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ovle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

### rtl/ordered_value_list_engine.sv
// Top level: insertion-ordered value list with append, search, edit, delete, dump.
// Append, and any request on an empty list: straight to S_EMIT, the result state.
// Search/edit: S_RD (RAM read), S_CMP (compare) per entry visited, then S_EMIT.
// Delete: as search, then S_SHRD and S_SHWR move each later entry down one slot.
// Dump: S_DRD then S_DOUT per entry; one request at a time, ready only while idle.
// Reset: synchronous active low; clears count, sequencer and output valid.
`default_nettype none
`include "assert_macros.svh"
module ordered_value_list_engine #(
    parameter int CAPACITY = ovle_pkg::CAPACITY_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire ovle_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output ovle_pkg::t_out_item      o_out_data
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    ovle_pkg::t_state    r_state, n_state;
    logic [IW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_count, n_count;
    logic [2:0]          r_func, n_func;
    logic [ovle_pkg::DATA_W-1:0] r_key, n_key;
    logic [ovle_pkg::DATA_W-1:0] r_nv, n_nv;
    logic [1:0]          r_pend, n_pend;
    logic                r_out_valid, n_out_valid;
    ovle_pkg::t_out_item r_out, n_out;

    logic                wr_en, rd_en;
    logic [IW-1:0]       wr_addr, rd_addr;
    logic [ovle_pkg::DATA_W-1:0] wr_data, rd_data;
    logic [CW-1:0]       idx_p1;
    logic                out_free;

    ovle_ram #(
        .WIDTH(ovle_pkg::DATA_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    assign idx_p1      = CW'(r_idx) + CW'(1);
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ovle_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ovle_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_idx  <= n_idx;
        r_func <= n_func;
        r_key  <= n_key;
        r_nv   <= n_nv;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_count     = r_count;
        n_func      = r_func;
        n_key       = r_key;
        n_nv        = r_nv;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        wr_en       = 1'b0;
        wr_addr     = r_idx;
        wr_data     = r_key;
        rd_en       = 1'b0;
        rd_addr     = r_idx;

        case (r_state)
            ovle_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_func = i_in_data.func;
                    n_key  = i_in_data.key;
                    n_nv   = i_in_data.new_value;
                    n_idx  = '0;
                    case (i_in_data.func) inside
                        ovle_pkg::FN_APPEND: begin
                            n_state = ovle_pkg::S_EMIT;
                            if (r_count >= CW'(CAPACITY)) begin
                                n_pend = ovle_pkg::ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = r_count[IW-1:0];
                                wr_data = i_in_data.key;
                                n_count = r_count + CW'(1);
                                n_pend  = ovle_pkg::ST_OK;
                            end
                        end
                        ovle_pkg::FN_SEARCH, ovle_pkg::FN_EDIT, ovle_pkg::FN_DELETE: begin
                            if (r_count == '0) begin
                                n_pend  = ovle_pkg::ST_EMPTY;
                                n_state = ovle_pkg::S_EMIT;
                            end else begin
                                n_state = ovle_pkg::S_RD;
                            end
                        end
                        ovle_pkg::FN_DUMP: begin
                            if (r_count == '0) begin
                                n_pend  = ovle_pkg::ST_EMPTY;
                                n_state = ovle_pkg::S_EMIT;
                            end else begin
                                n_state = ovle_pkg::S_DRD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ovle_pkg::S_RD: begin
                rd_en   = 1'b1;
                n_state = ovle_pkg::S_CMP;
            end
            ovle_pkg::S_CMP: begin
                if (rd_data == r_key) begin
                    n_pend  = ovle_pkg::ST_OK;
                    n_state = ovle_pkg::S_EMIT;
                    case (r_func)
                        ovle_pkg::FN_EDIT: begin
                            wr_en   = 1'b1;
                            wr_data = r_nv;
                        end
                        ovle_pkg::FN_DELETE: begin
                            if (idx_p1 < r_count) begin
                                n_state = ovle_pkg::S_SHRD;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        default: ;
                    endcase
                end else if (idx_p1 == r_count) begin
                    n_pend  = ovle_pkg::ST_NOT_FOUND;
                    n_state = ovle_pkg::S_EMIT;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = ovle_pkg::S_RD;
                end
            end
            ovle_pkg::S_SHRD: begin
                rd_en   = 1'b1;
                rd_addr = r_idx + IW'(1);
                n_state = ovle_pkg::S_SHWR;
            end
            ovle_pkg::S_SHWR: begin
                wr_en   = 1'b1;
                wr_data = rd_data;
                n_idx   = r_idx + IW'(1);
                if ((idx_p1 + CW'(1)) < r_count) begin
                    n_state = ovle_pkg::S_SHRD;
                end else begin
                    n_count = r_count - CW'(1);
                    n_pend  = ovle_pkg::ST_OK;
                    n_state = ovle_pkg::S_EMIT;
                end
            end
            ovle_pkg::S_DRD: begin
                rd_en   = 1'b1;
                n_state = ovle_pkg::S_DOUT;
            end
            ovle_pkg::S_DOUT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out.status = ovle_pkg::ST_OK;
                    n_out.value  = rd_data;
                    n_out.last   = (idx_p1 == r_count);
                    if (idx_p1 == r_count) begin
                        n_state = ovle_pkg::S_IDLE;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = ovle_pkg::S_DRD;
                    end
                end
            end
            ovle_pkg::S_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out.status = r_pend;
                    n_out.value  = '0;
                    n_out.last   = 1'b1;
                    n_state      = ovle_pkg::S_IDLE;
                end
            end
            default: n_state = ovle_pkg::S_IDLE;
        endcase
    end

    `ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY),
        "count over capacity")
    `ASSERT_NEXT(a_append_grows, i_clk, i_rst_n,
        i_in_valid && o_in_ready && i_in_data.func == ovle_pkg::FN_APPEND
            && r_count < CW'(CAPACITY),
        r_count == $past(r_count) + CW'(1), "append lost")
    `ASSERT_IMPL(a_nonlast_ok, i_clk, i_rst_n, o_out_valid && !o_out_data.last,
        o_out_data.status == ovle_pkg::ST_OK, "non-final beat not ok")
    `ASSERT_IMPL(a_shift_range, i_clk, i_rst_n, r_state == ovle_pkg::S_SHWR,
        idx_p1 < r_count, "shift past tail")

endmodule
`default_nettype wire
